@@ rtl/etf_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// etf_pkg: shared types and constants of the escape-time fractal pixel block
// Register indexes, configuration and status bundles, sequencer states and
// the saturating add used by the coordinate and iteration datapath.
// ---------------------------------------------------------------------------
package etf_pkg;

  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CFG_ADDR_W-1:0] REG_JULIA_MODE = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_MAX_ITER   = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_ORIGIN_RE  = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_ORIGIN_IM  = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_STEP_SIZE  = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_JULIA_RE   = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] REG_JULIA_IM   = 3'd6;
  localparam logic [CFG_ADDR_W-1:0] REG_HEIGHT     = 3'd7;

  typedef struct packed {
    logic        julia_mode;
    logic [15:0] max_iter;
    logic [31:0] origin_re;
    logic [31:0] origin_im;
    logic [30:0] step_size;
    logic [31:0] julia_re;
    logic [31:0] julia_im;
    logic [12:0] height;
  } cfg_t;

  typedef struct packed {
    logic idle;
    logic done;
  } stat_t;

  typedef struct packed {
    logic [7:0]  escape_value;
    logic [11:0] col;
    logic [11:0] row;
  } res_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PT_RE,
    ST_PT_IM,
    ST_PT_SET,
    ST_SQ_RE,
    ST_SQ_IM,
    ST_CROSS,
    ST_DONE
  } state_e;

  // a + b, clamped to the signed 32-bit range
  function automatic logic signed [31:0] sat_add(input logic signed [63:0] a,
                                                 input logic signed [31:0] b);
    logic signed [64:0] s;
    s = 65'(a) + 65'(b);
    if (s[64:31] == '0 || s[64:31] == '1) begin
      return s[31:0];
    end else if (s[64]) begin
      return 32'sh8000_0000;
    end else begin
      return 32'sh7fff_ffff;
    end
  endfunction

endpackage
`default_nettype wire

@@ rtl/etf_mul.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// etf_mul: shared signed 32x32 multiplier
// Full 64-bit product, registered; the result appears in the cycle after the
// operands.
// ---------------------------------------------------------------------------
module etf_mul (
  input  wire logic               clk_i,
  input  wire logic signed [31:0] a_i,
  input  wire logic signed [31:0] b_i,
  output logic signed [63:0]      p_o
);

  logic signed [63:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= 64'(a_i) * 64'(b_i);
  end

  assign p_o = p_q;

endmodule
`default_nettype wire

@@ rtl/etf_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// etf_core: escape-time sequencer and datapath
// Maps a pixel to its complex point and iterates z = z*z + c, issuing the
// three products of each iteration to one shared multiplier.
// ---------------------------------------------------------------------------
module etf_core #(
  parameter int unsigned FRAC_BITS = 28
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire etf_pkg::cfg_t cfg_i,
  input  wire logic          start_i,
  input  wire logic [11:0]   col_i,
  input  wire logic [11:0]   row_i,
  input  wire logic          take_i,
  output etf_pkg::stat_t     stat_o,
  output etf_pkg::res_t      res_o
);

  // |z|^2 >= 4.0 on the unshifted sum of squares
  localparam int unsigned EscShift = 2 * FRAC_BITS + 2;

  etf_pkg::state_e    state_q, state_d;
  logic [11:0]        col_q, col_d, row_q, row_d;
  logic signed [31:0] pre_q, pre_d;
  logic signed [31:0] zre_q, zre_d, zim_q, zim_d;
  logic signed [31:0] cre_q, cre_d, cim_q, cim_d;
  logic signed [63:0] sq_re_q, sq_re_d;
  logic [15:0]        count_q, count_d;
  logic               first_q, first_d;

  logic signed [31:0] op_a, op_b;
  logic signed [63:0] prod;
  logic signed [63:0] sq_diff;
  logic [63:0]        mag_sum;
  logic               escape;
  logic signed [31:0] zre_upd, zim_upd, pt_re, pt_im;
  logic [16:0]        count_inc;

  etf_mul u_mul (
    .clk_i (clk_i),
    .a_i   (op_a),
    .b_i   (op_b),
    .p_o   (prod)
  );

  assign sq_diff   = sq_re_q - prod;
  assign mag_sum   = $unsigned(sq_re_q) + $unsigned(prod);
  assign escape    = (mag_sum >> EscShift) != '0;
  assign zre_upd   = etf_pkg::sat_add(sq_diff >>> FRAC_BITS, cre_q);
  assign zim_upd   = etf_pkg::sat_add(prod >>> (FRAC_BITS - 1), cim_q);
  assign pt_re     = etf_pkg::sat_add(prod, $signed(cfg_i.origin_re));
  assign pt_im     = etf_pkg::sat_add(prod, $signed(cfg_i.origin_im));
  assign count_inc = {1'b0, count_q} + 17'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= etf_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    col_q   <= col_d;
    row_q   <= row_d;
    pre_q   <= pre_d;
    zre_q   <= zre_d;
    zim_q   <= zim_d;
    cre_q   <= cre_d;
    cim_q   <= cim_d;
    sq_re_q <= sq_re_d;
    count_q <= count_d;
    first_q <= first_d;
  end

  always_comb begin
    state_d = state_q;
    col_d   = col_q;
    row_d   = row_q;
    pre_d   = pre_q;
    zre_d   = zre_q;
    zim_d   = zim_q;
    cre_d   = cre_q;
    cim_d   = cim_q;
    sq_re_d = sq_re_q;
    count_d = count_q;
    first_d = first_q;
    op_a    = '0;
    op_b    = '0;
    unique case (state_q)
      etf_pkg::ST_IDLE: begin
        if (start_i) begin
          col_d   = col_i;
          row_d   = row_i;
          state_d = etf_pkg::ST_PT_RE;
        end
      end
      etf_pkg::ST_PT_RE: begin
        op_a    = {20'd0, col_q};
        op_b    = {1'b0, cfg_i.step_size};
        state_d = etf_pkg::ST_PT_IM;
      end
      etf_pkg::ST_PT_IM: begin
        op_a    = {20'd0, row_q};
        op_b    = {1'b0, cfg_i.step_size};
        pre_d   = pt_re;
        state_d = etf_pkg::ST_PT_SET;
      end
      etf_pkg::ST_PT_SET: begin
        count_d = '0;
        first_d = 1'b1;
        if (cfg_i.julia_mode) begin
          zre_d = pre_q;
          zim_d = pt_im;
          cre_d = $signed(cfg_i.julia_re);
          cim_d = $signed(cfg_i.julia_im);
        end else begin
          zre_d = '0;
          zim_d = '0;
          cre_d = pre_q;
          cim_d = pt_im;
        end
        state_d = (cfg_i.max_iter == '0) ? etf_pkg::ST_DONE : etf_pkg::ST_SQ_RE;
      end
      etf_pkg::ST_SQ_RE: begin
        op_a = zre_q;
        op_b = zre_q;
        // cross product of the previous iteration is on the multiplier output
        if (!first_q) begin
          zim_d = zim_upd;
        end
        first_d = 1'b0;
        state_d = etf_pkg::ST_SQ_IM;
      end
      etf_pkg::ST_SQ_IM: begin
        op_a    = zim_q;
        op_b    = zim_q;
        sq_re_d = prod;
        state_d = etf_pkg::ST_CROSS;
      end
      etf_pkg::ST_CROSS: begin
        op_a = zre_q;
        op_b = zim_q;
        if (escape) begin
          state_d = etf_pkg::ST_DONE;
        end else begin
          zre_d   = zre_upd;
          count_d = count_inc[15:0];
          state_d = (count_inc < {1'b0, cfg_i.max_iter}) ? etf_pkg::ST_SQ_RE
                                                          : etf_pkg::ST_DONE;
        end
      end
      etf_pkg::ST_DONE: begin
        if (take_i) begin
          state_d = etf_pkg::ST_IDLE;
        end
      end
    endcase
  end

  assign stat_o.idle         = (state_q == etf_pkg::ST_IDLE);
  assign stat_o.done         = (state_q == etf_pkg::ST_DONE);
  assign res_o.escape_value  = count_q[7:0];
  assign res_o.col           = col_q;
  assign res_o.row           = row_q;

endmodule
`default_nettype wire

@@ rtl/escape_time_fractal_pixel_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// escape_time_fractal_pixel_top: Mandelbrot / Julia escape-time pixel engine
// Configuration registers, input handshake, row flip and output register
// around the iteration core.
// ---------------------------------------------------------------------------
// Channel | Direction | Handshake           | Beat
// cfg     | in        | cfg_we_i            | cfg_addr_i, cfg_wdata_i
// in      | in        | in_valid_i/stall_o  | pixel_col_i, pixel_row_i
// out     | out       | out_valid_o/stall_i | escape_value_o, out_col_o, out_row_o
//
// A pixel runs from accept through the point mapping and N rounds, N being the
// iterations run (escape detected on iteration N, or N = max_iterations).
// The single 32x32 multiplier forms three products per iteration.
// Reset is asynchronous; no clearing pass. in_stall_o is high while a pixel
// is in work; a result waiting on out_stall_i blocks only the next hand-off.
// ---------------------------------------------------------------------------
module escape_time_fractal_pixel_top #(
  parameter int unsigned MAX_HEIGHT = 4096,
  parameter int unsigned FRAC_BITS  = 28
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [etf_pkg::CFG_ADDR_W-1:0]   cfg_addr_i,
  input  wire logic [etf_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  input  wire logic                             in_valid_i,
  output logic                                  in_stall_o,
  input  wire logic [11:0]                      pixel_col_i,
  input  wire logic [11:0]                      pixel_row_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_stall_i,
  output logic [7:0]                            escape_value_o,
  output logic [11:0]                           out_col_o,
  output logic [11:0]                           out_row_o
);

  localparam logic [16:0] MaxHeight = 17'(MAX_HEIGHT);

  etf_pkg::cfg_t  cfg_q;
  etf_pkg::stat_t stat;
  etf_pkg::res_t  res;

  logic        in_accept;
  logic        out_load;
  logic        out_valid_q, out_valid_d;
  logic [7:0]  esc_q;
  logic [11:0] col_q, row_q;
  logic [16:0] height_cl;

  assign in_stall_o = !stat.idle;
  assign in_accept  = in_valid_i && stat.idle;
  assign out_load   = stat.done && (!out_valid_q || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.julia_mode <= 1'b0;
      cfg_q.max_iter   <= 16'd255;
      cfg_q.origin_re  <= '0;
      cfg_q.origin_im  <= '0;
      cfg_q.step_size  <= 31'd268435;
      cfg_q.julia_re   <= '0;
      cfg_q.julia_im   <= '0;
      cfg_q.height     <= 13'd4096;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        etf_pkg::REG_JULIA_MODE: cfg_q.julia_mode <= cfg_wdata_i[0];
        etf_pkg::REG_MAX_ITER:   cfg_q.max_iter   <= cfg_wdata_i[15:0];
        etf_pkg::REG_ORIGIN_RE:  cfg_q.origin_re  <= cfg_wdata_i;
        etf_pkg::REG_ORIGIN_IM:  cfg_q.origin_im  <= cfg_wdata_i;
        etf_pkg::REG_STEP_SIZE:  cfg_q.step_size  <= cfg_wdata_i[30:0];
        etf_pkg::REG_JULIA_RE:   cfg_q.julia_re   <= cfg_wdata_i;
        etf_pkg::REG_JULIA_IM:   cfg_q.julia_im   <= cfg_wdata_i;
        etf_pkg::REG_HEIGHT:     cfg_q.height     <= cfg_wdata_i[12:0];
      endcase
    end
  end

  etf_core #(
    .FRAC_BITS (FRAC_BITS)
  ) u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .start_i (in_accept),
    .col_i   (pixel_col_i),
    .row_i   (pixel_row_i),
    .take_i  (out_load),
    .stat_o  (stat),
    .res_o   (res)
  );

  assign height_cl = ({4'd0, cfg_q.height} > MaxHeight) ? MaxHeight : {4'd0, cfg_q.height};

  always_comb begin
    out_valid_d = out_valid_q;
    priority if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      esc_q <= res.escape_value;
      col_q <= res.col;
      row_q <= height_cl[11:0] - 12'd1 - res.row;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign escape_value_o = esc_q;
  assign out_col_o      = col_q;
  assign out_row_o      = row_q;

`ifndef NO_ASSERTIONS
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("block ready right after taking a pixel");

  a_count_in_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && cfg_q.max_iter < 16'd256) |=> ({8'd0, escape_value_o} <= cfg_q.max_iter))
    else $error("escape value above iteration limit");

  a_out_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && !stat.done) |=> !out_valid_o)
    else $error("taken beat not retired from output register");
`endif

endmodule
`default_nettype wire
